@@ rtl/iirlp_pkg.sv @@
// ----------------------------------------------------------------------------
// iirlp_pkg
// Shared types and constants of the second-order low-pass IIR filter.
// ----------------------------------------------------------------------------
package iirlp_pkg;

   // coefficient word: signed, fraction bits set by the top level
   localparam int COEF_BITS = 32;

   // the accumulator wraps at this width
   localparam int ACC_LIMIT_BITS = 64;

   // register index width on the csr port
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FEEDFORWARD_GAIN = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FEEDBACK_ONE     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FEEDBACK_TWO     = 2'd2;

   // 20 Hz cutoff, damping 0.707, 100 us sample period, Q4.28
   localparam logic signed [COEF_BITS-1:0] GAIN_RESET = 32'sd10504;
   localparam logic signed [COEF_BITS-1:0] FB_ONE_RESET = -32'sd532101301;
   localparam logic signed [COEF_BITS-1:0] FB_TWO_RESET = 32'sd263707852;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] gain;
      logic signed [COEF_BITS-1:0] fb_one;
      logic signed [COEF_BITS-1:0] fb_two;
   } coef_type;

endpackage

@@ rtl/iirlp_calc.sv @@
// ----------------------------------------------------------------------------
// iirlp_calc
// One biquad step: tap sum, three products, round and saturate.
// ----------------------------------------------------------------------------
module iirlp_calc
   import iirlp_pkg::*;
#(
   parameter int SAMPLE_BITS        = 16,
   parameter int COEF_FRACTION_BITS = 28
) (
   input  coef_type                       coef,
   input  logic signed [SAMPLE_BITS-1:0]  x0,
   input  logic signed [SAMPLE_BITS-1:0]  x1,
   input  logic signed [SAMPLE_BITS-1:0]  x2,
   input  logic signed [SAMPLE_BITS-1:0]  y1,
   input  logic signed [SAMPLE_BITS-1:0]  y2,
   output logic signed [SAMPLE_BITS-1:0]  y0
);

   localparam int TAP_W  = SAMPLE_BITS + 2;
   localparam int PROD_W = COEF_BITS + TAP_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int ACC_W  = (SUM_W + 1 < ACC_LIMIT_BITS) ? SUM_W + 1 : ACC_LIMIT_BITS;
   localparam int Q_W    = ACC_W - COEF_FRACTION_BITS;
   localparam logic signed [ACC_W-1:0] ROUND_HALF =
      ACC_W'(1) <<< (COEF_FRACTION_BITS - 1);
   localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [TAP_W-1:0]  tap_sum;
   logic signed [PROD_W-1:0] ff_prod;
   logic signed [PROD_W-1:0] fb_one_prod;
   logic signed [PROD_W-1:0] fb_two_prod;
   logic signed [SUM_W-1:0]  sum_wide;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  rounded;
   logic signed [Q_W-1:0]    quot;
   logic [Q_W-SAMPLE_BITS:0] top_bits;

   assign tap_sum = TAP_W'(x0) + (TAP_W'(x1) <<< 1) + TAP_W'(x2);

   assign ff_prod     = PROD_W'(coef.gain)   * PROD_W'(tap_sum);
   assign fb_one_prod = PROD_W'(coef.fb_one) * PROD_W'(y1);
   assign fb_two_prod = PROD_W'(coef.fb_two) * PROD_W'(y2);

   assign sum_wide = SUM_W'(ff_prod) - SUM_W'(fb_one_prod) - SUM_W'(fb_two_prod);

   // wrap at the accumulator limit only for very wide samples
   generate
      if (ACC_W > SUM_W) begin : g_extend
         assign acc = {sum_wide[SUM_W-1], sum_wide};
      end else begin : g_wrap
         assign acc = sum_wide[ACC_W-1:0];
      end
   endgenerate

   // halves round toward plus infinity
   assign rounded  = acc + ROUND_HALF;
   assign quot     = rounded[ACC_W-1:COEF_FRACTION_BITS];
   assign top_bits = quot[Q_W-1:SAMPLE_BITS-1];

   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         y0 = quot[SAMPLE_BITS-1:0];
      end else if (quot[Q_W-1]) begin
         y0 = SAT_MIN;
      end else begin
         y0 = SAT_MAX;
      end
   end

endmodule

@@ rtl/second_order_iir_lowpass_unit.sv @@
// ----------------------------------------------------------------------------
// second_order_iir_lowpass_unit
// Direct form I low-pass biquad with programmable Q4.28 coefficients.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_sample_in
//   rsp      out        rsp_valid/rsp_stall  rsp_sample_out
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// one word a cycle unless rsp stalls; words pass the input, then output register
// the rate is set by the output feedback loop: y1 through its product,
// the sum, rounding and saturation back into y1 as one combinational path
// reset clears the sample history and loads the 20 Hz coefficient set
// a stalled rsp word holds its register; req stalls only while a word waits
// in the input register behind it, so nothing is lost or repeated
// csr writes are always ready and take effect on the next sample
// ----------------------------------------------------------------------------
module second_order_iir_lowpass_unit
   import iirlp_pkg::*;
#(
   parameter int SAMPLE_BITS        = 16,
   parameter int COEF_FRACTION_BITS = 28
) (
   input  logic                          clock,
   input  logic                          reset,
   // sample input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   // filtered output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   // coefficient writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [COEF_BITS-1:0]          csr_wdata
);

   // input register
   logic                          in_valid_ff;
   logic signed [SAMPLE_BITS-1:0] in_sample_ff;

   // output register
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff;

   // sample history
   logic signed [SAMPLE_BITS-1:0] x1_ff;
   logic signed [SAMPLE_BITS-1:0] x2_ff;
   logic signed [SAMPLE_BITS-1:0] y1_ff;
   logic signed [SAMPLE_BITS-1:0] y2_ff;

   // coefficients
   coef_type coef_ff;
   coef_type coef_in;

   logic                          advance;
   logic                          req_take;
   logic signed [SAMPLE_BITS-1:0] y0;

   // the input word moves on when the output register is free or emptying
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;
   assign csr_ready      = 1'b1;

   // register decode, unknown indexes are dropped
   always_comb begin
      coef_in = coef_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FEEDFORWARD_GAIN: coef_in.gain   = signed'(csr_wdata);
            CSR_FEEDBACK_ONE:     coef_in.fb_one = signed'(csr_wdata);
            CSR_FEEDBACK_TWO:     coef_in.fb_two = signed'(csr_wdata);
            default:              coef_in = coef_ff;
         endcase
      end
   end

   iirlp_calc #(
      .SAMPLE_BITS        (SAMPLE_BITS),
      .COEF_FRACTION_BITS (COEF_FRACTION_BITS)
   ) u_calc (
      .coef (coef_ff),
      .x0   (in_sample_ff),
      .x1   (x1_ff),
      .x2   (x2_ff),
      .y1   (y1_ff),
      .y2   (y2_ff),
      .y0   (y0)
   );

   // control, history and coefficients
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         coef_ff.gain   <= GAIN_RESET;
         coef_ff.fb_one <= FB_ONE_RESET;
         coef_ff.fb_two <= FB_TWO_RESET;
      end else begin
         in_valid_ff  <= req_take || (in_valid_ff && !advance);
         out_valid_ff <= out_valid_in;
         coef_ff      <= coef_in;
         // history shifts once per filtered word, saturated value fed back
         if (advance) begin
            x2_ff <= x1_ff;
            x1_ff <= in_sample_ff;
            y2_ff <= y1_ff;
            y1_ff <= y0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_ff <= req_sample_in;
      end
      if (advance) begin
         out_sample_ff <= y0;
      end
   end

endmodule

@@ rtl/iirlp_checker.sv @@
// ----------------------------------------------------------------------------
// iirlp_checker
// Port-level checks of the low-pass filter handshake and flow.
// ----------------------------------------------------------------------------
module iirlp_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [SAMPLE_BITS-1:0] rsp_sample_out
);

   // no word is shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a waiting output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out))
      else $error("stalled rsp word changed");

   // input stalls only behind a blocked output word
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled with output free");

   // a taken word reaches the output once the output side is free
   a_flow: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 (!rsp_valid || !rsp_stall) |=> rsp_valid)
      else $error("accepted word did not reach rsp");

endmodule

bind second_order_iir_lowpass_unit iirlp_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out)
);

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the second-order low-pass IIR unit. A bit-true
// biquad predictor runs beside the block. Each accepted sample word is
// predicted, and each output word is checked against the oldest prediction.
// Coefficient sets change between phases while the filter is idle. In
// phases with idling enabled, both handshakes get random idle bursts.
// ----------------------------------------------------------------------------
module tb_top
   import iirlp_pkg::*;
;

   localparam int SAMPLE_W    = 16;
   localparam int COEF_FRAC   = 28;
   localparam int DRAIN_PAUSE = 6;      // rsp lags req through the input and output registers, plus margin
   localparam int CYCLE_LIMIT = 200000;

   // only three registers exist, so a write here must change nothing
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 2'd3;

   localparam longint SAMPLE_HI  = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_LO  = -SAMPLE_HI - 1;
   localparam longint ROUND_BIAS = longint'(1) <<< (COEF_FRAC - 1);

   localparam logic signed [SAMPLE_W-1:0] FULL_POS = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 16'sh8000;

   // clock and the single reset at the start
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   // block ports, every input driven to a known value from time zero
   logic                         req_valid     = 1'b0;
   logic                         req_stall;
   logic signed [SAMPLE_W-1:0]   req_sample_in = '0;
   logic                         rsp_valid;
   logic                         rsp_stall     = 1'b0;
   logic signed [SAMPLE_W-1:0]   rsp_sample_out;
   logic                         csr_valid     = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_BITS-1:0]    csr_index     = '0;
   logic [COEF_BITS-1:0]         csr_wdata     = '0;

   second_order_iir_lowpass_unit #(
      .SAMPLE_BITS        (SAMPLE_W),
      .COEF_FRACTION_BITS (COEF_FRAC)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // predictor copy of the coefficients, starting from the 20 Hz set
   logic signed [COEF_BITS-1:0] gain_q   = GAIN_RESET;
   logic signed [COEF_BITS-1:0] fb_one_q = FB_ONE_RESET;
   logic signed [COEF_BITS-1:0] fb_two_q = FB_TWO_RESET;

   // predictor copy of the sample history, cleared like the block at reset
   logic signed [SAMPLE_W-1:0] x_one = '0;
   logic signed [SAMPLE_W-1:0] x_two = '0;
   logic signed [SAMPLE_W-1:0] y_one = '0;
   logic signed [SAMPLE_W-1:0] y_two = '0;

   logic signed [SAMPLE_W-1:0] samples_to_send[$];   // words the driver still has to offer
   logic signed [SAMPLE_W-1:0] filtered_due[$];      // predicted outputs, oldest first
   logic signed [SAMPLE_W-1:0] last_sample = '0;
   logic signed [SAMPLE_W-1:0] due_sample;

   logic idle_enable   = 1'b0;   // random bursts on both sides when set
   int   send_gap      = 0;
   int   stall_left    = 0;
   int   mismatch_count = 0;
   int   cycle_count   = 0;

   // one filter step: 64-bit wrapping accumulate, round half up, clamp,
   // and the clamped value goes back into the output history
   function automatic logic signed [SAMPLE_W-1:0] biquad_step(
      input logic signed [SAMPLE_W-1:0] x_new
   );
      longint                     taps;
      longint                     acc;
      longint                     rounded;
      logic signed [SAMPLE_W-1:0] y_new;
      taps = longint'(x_new) + 2 * longint'(x_one) + longint'(x_two);
      acc  = longint'(gain_q) * taps;
      acc  = acc - longint'(fb_one_q) * longint'(y_one);
      acc  = acc - longint'(fb_two_q) * longint'(y_two);
      acc  = acc + ROUND_BIAS;
      rounded = acc >>> COEF_FRAC;
      if (rounded > SAMPLE_HI) begin
         rounded = SAMPLE_HI;
      end else if (rounded < SAMPLE_LO) begin
         rounded = SAMPLE_LO;
      end
      y_new = rounded[SAMPLE_W-1:0];
      x_two = x_one;
      x_one = x_new;
      y_two = y_one;
      y_one = y_new;
      return y_new;
   endfunction

   // moderate coefficients so the output moves, with extremes, zero and raw
   // bit patterns mixed in
   function automatic logic [COEF_BITS-1:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return '0;
         default: return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
      endcase
   endfunction

   // random sample words: full range, rail values, small noise and held
   // steps so the recursion settles and rings
   task automatic queue_random(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1: last_sample = SAMPLE_W'($urandom());
            2: last_sample = $urandom_range(0, 1) ? FULL_POS : FULL_NEG;
            3, 4: last_sample = SAMPLE_W'($urandom_range(0, 200) - 100);
            5, 6: ;   // hold the previous value
            default: last_sample = SAMPLE_W'($urandom_range(0, 8192) - 4096);
         endcase
         samples_to_send.push_back(last_sample);
      end
   endtask

   // one csr write, mirrored into the predictor at the edge it lands on
   task automatic write_reg(
      input logic [CSR_INDEX_BITS-1:0] idx,
      input logic [COEF_BITS-1:0]      data
   );
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FEEDFORWARD_GAIN: gain_q   = data;
         CSR_FEEDBACK_ONE:     fb_one_q = data;
         CSR_FEEDBACK_TWO:     fb_two_q = data;
         default: ;
      endcase
   endtask

   task automatic load_coefs(
      input logic [COEF_BITS-1:0] gain,
      input logic [COEF_BITS-1:0] fb_one,
      input logic [COEF_BITS-1:0] fb_two
   );
      write_reg(CSR_FEEDFORWARD_GAIN, gain);
      write_reg(CSR_FEEDBACK_ONE, fb_one);
      write_reg(CSR_FEEDBACK_TWO, fb_two);
      @(negedge clock);
   endtask

   // wait until every word has gone in and every prediction has come out
   task automatic settle();
      while (samples_to_send.size() != 0 || req_valid || filtered_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_PAUSE) @(negedge clock);
   endtask

   // driver: offers queued words, holds a stalled word, predicts on accept
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            filtered_due.push_back(biquad_step(req_sample_in));
         end
         // a stalled word stays put until it is taken
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (samples_to_send.size() == 0) begin
               req_valid <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
               // start an idle burst
               send_gap = $urandom_range(0, 6);
               req_valid <= 1'b0;
            end else begin
               req_valid     <= 1'b1;
               req_sample_in <= samples_to_send.pop_front();
            end
         end
      end
   end

   // monitor: checks each taken output word, and stalls the output in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (filtered_due.size() == 0) begin
               $display("%0t: sample_out %0d arrived with no sample pending",
                        $time, rsp_sample_out);
               mismatch_count++;
            end else begin
               due_sample = filtered_due.pop_front();
               if (rsp_sample_out !== due_sample) begin
                  $display("%0t: sample_out mismatch, expected %0d actual %0d",
                           $time, due_sample, rsp_sample_out);
                  mismatch_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            // start a stall burst
            stall_left = $urandom_range(0, 6);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: no progress after %0d cycles", $time, cycle_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   // stimulus: directed phases, then random phases over several
   // coefficient sets, the last one without idling
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset coefficient set, rail to rail inputs into a cleared history
      samples_to_send.push_back(16'sd0);
      samples_to_send.push_back(FULL_POS);
      samples_to_send.push_back(FULL_POS);
      samples_to_send.push_back(FULL_NEG);
      samples_to_send.push_back(FULL_NEG);
      samples_to_send.push_back(FULL_POS);
      samples_to_send.push_back(16'sd0);
      samples_to_send.push_back(16'sd1);
      settle();

      // gain of one half, no feedback: odd tap sums land on exact halves,
      // which must round toward plus infinity on both signs
      load_coefs(32'h0800_0000, '0, '0);
      samples_to_send.push_back(16'sd1);
      samples_to_send.push_back(16'sd0);
      samples_to_send.push_back(16'sd0);
      samples_to_send.push_back(-16'sd1);
      samples_to_send.push_back(16'sd0);
      samples_to_send.push_back(16'sd0);
      samples_to_send.push_back(FULL_POS);
      samples_to_send.push_back(FULL_NEG);
      settle();

      // largest gain drives the output into both rails; the write to the
      // unused index must leave the coefficients alone
      write_reg(CSR_UNUSED_INDEX, 32'hFFFF_FFFF);
      load_coefs(32'h7FFF_FFFF, '0, '0);
      samples_to_send.push_back(FULL_POS);
      samples_to_send.push_back(FULL_NEG);
      samples_to_send.push_back(16'sd100);
      samples_to_send.push_back(-16'sd100);
      samples_to_send.push_back(16'sd0);
      samples_to_send.push_back(16'sd0);
      settle();

      // back to the 20 Hz design with random traffic and idling
      load_coefs(GAIN_RESET, FB_ONE_RESET, FB_TWO_RESET);
      idle_enable = 1'b1;
      queue_random(90);
      settle();

      // unity taps, no feedback: output is the clamped tap sum
      load_coefs(32'h1000_0000, '0, '0);
      queue_random(70);
      settle();

      // coefficient extremes of opposite signs
      load_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_random(60);
      settle();
      load_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_random(60);
      settle();

      // random coefficient sets, some phases without idling
      for (int p = 0; p < 5; p++) begin
         if ($urandom_range(0, 1) == 1) begin
            write_reg(CSR_UNUSED_INDEX, $urandom());
         end
         load_coefs(pick_coef(), pick_coef(), pick_coef());
         idle_enable = ($urandom_range(0, 3) != 0);
         queue_random(60);
         settle();
      end

      // last stretch at full rate on the default design
      load_coefs(GAIN_RESET, FB_ONE_RESET, FB_TWO_RESET);
      idle_enable = 1'b0;
      queue_random(60);
      settle();

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
